// ===== src/dts_pkg.sv =====
// Shared types and constants for the dependency table sweep block.
package dts_pkg;

  localparam int unsigned MAX_STEPS_DEF = 256;
  localparam int unsigned MAX_DEPS_DEF  = 32;
  localparam int unsigned ID_W          = 10;
  localparam int unsigned OUT_W         = 9;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e            command;
    logic [ID_W-1:0] dep_id;
    logic [ID_W-1:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] new_step_id;
    logic [OUT_W-1:0] tally;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] target;
  } sweep_req_t;

endpackage

// ===== src/dependency_table_dead_step_sweep_core.sv =====
// Append, close and query: result is registered in the output register; one item per cycle while the output is free.
// Sweep: clears the reach mark of every used step, pushes the target, then pops steps and scans
// their dependency edges through the single read port of each table RAM, then tallies dead steps.
// A new item is taken while a finished result waits in the output register.
// Reset clears the step counters, open count and handshake state; the RAMs are not
// swept, since every entry is written before it is read.
module dependency_table_dead_step_sweep_core #(
  parameter int unsigned MAX_STEPS = dts_pkg::MAX_STEPS_DEF,
  parameter int unsigned MAX_DEPS  = dts_pkg::MAX_DEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dts_pkg::out_item_t out_item_o
);

  localparam int unsigned SW    = $clog2(MAX_STEPS);
  localparam int unsigned DW    = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int unsigned UW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW    = $clog2(MAX_DEPS + 1);
  localparam int unsigned OUT_W = dts_pkg::OUT_W;

  typedef enum logic [1:0] {
    T_IDLE, T_SWEEP, T_HOLD
  } state_e;

  state_e             state_q;
  logic [UW-1:0]      used_q;
  logic [UW-1:0]      live_q;
  logic [CW-1:0]      open_q;
  logic               out_valid_q;
  dts_pkg::out_item_t out_item_q;
  dts_pkg::out_item_t res_q;

  logic               accept, out_free, full, dropped;
  logic [UW-1:0]      used_next;
  dts_pkg::out_item_t res_simple, res_sweep;
  dts_pkg::sweep_req_t sweep_req;
  logic               out_load;
  dts_pkg::out_item_t out_item_d;

  logic                  dep_we, close_we;
  logic [SW+DW-1:0]      dep_waddr, dep_raddr;
  logic [dts_pkg::ID_W-1:0] dep_rdata;
  logic [SW-1:0]         cnt_raddr;
  logic [CW-1:0]         cnt_rdata;
  logic                  sw_done;
  logic [UW-1:0]         sw_tally;

  assign in_stall_o = (state_q != T_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (used_q >= UW'(MAX_STEPS));
  assign dropped    = (open_q >= CW'(MAX_DEPS));
  assign used_next  = used_q + UW'(1);

  assign dep_we    = accept && (in_item_i.command == dts_pkg::CMD_APPEND) && !dropped && !full;
  assign close_we  = accept && (in_item_i.command == dts_pkg::CMD_CLOSE) && !full;
  assign dep_waddr = {used_q[SW-1:0], open_q[DW-1:0]};

  assign sweep_req = '{start:  accept && (in_item_i.command == dts_pkg::CMD_SWEEP),
                       target: in_item_i.target_id};

  always_comb begin
    res_simple.status      = dts_pkg::ST_OK;
    res_simple.new_step_id = '0;
    res_simple.tally       = '0;
    unique case (in_item_i.command)
      dts_pkg::CMD_APPEND: begin
        if (dropped) begin
          res_simple.status = dts_pkg::ST_DROPPED;
        end
      end
      dts_pkg::CMD_CLOSE: begin
        if (full) begin
          res_simple.status = dts_pkg::ST_FULL;
        end else begin
          res_simple.new_step_id = OUT_W'(used_next);
        end
      end
      dts_pkg::CMD_QUERY: begin
        res_simple.tally = OUT_W'(live_q);
      end
      default: ;
    endcase
    res_sweep.status      = dts_pkg::ST_OK;
    res_sweep.new_step_id = '0;
    res_sweep.tally       = OUT_W'(sw_tally);
  end

  // Pick what loads the output register this cycle.
  always_comb begin
    out_load   = 1'b0;
    out_item_d = res_q;
    unique case (state_q)
      T_IDLE: begin
        out_load   = accept && (in_item_i.command != dts_pkg::CMD_SWEEP) && out_free;
        out_item_d = res_simple;
      end
      T_SWEEP: begin
        out_load   = sw_done && out_free;
        out_item_d = res_sweep;
      end
      T_HOLD: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      used_q      <= '0;
      live_q      <= '0;
      open_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      res_q       <= '0;
    end else begin
      // Load a new result, or drop the output once its transfer completes.
      if (out_load) begin
        out_item_q  <= out_item_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            unique case (in_item_i.command)
              dts_pkg::CMD_APPEND: begin
                if (!dropped) begin
                  open_q <= open_q + CW'(1);
                end
              end
              dts_pkg::CMD_CLOSE: begin
                if (!full) begin
                  used_q <= used_next;
                  live_q <= live_q + UW'(1);
                end
                open_q <= '0;
              end
              dts_pkg::CMD_SWEEP: begin
                state_q <= T_SWEEP;
              end
              default: ;
            endcase
            if (in_item_i.command != dts_pkg::CMD_SWEEP) begin
              if (!out_free) begin
                res_q   <= res_simple;
                state_q <= T_HOLD;
              end
            end
          end
        end
        T_SWEEP: begin
          if (sw_done) begin
            live_q <= live_q - sw_tally;
            if (out_free) begin
              state_q <= T_IDLE;
            end else begin
              res_q   <= res_sweep;
              state_q <= T_HOLD;
            end
          end
        end
        T_HOLD: begin
          if (out_free) begin
            state_q <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  dts_ram #(.WIDTH(dts_pkg::ID_W), .DEPTH(MAX_STEPS * (1 << DW))) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (in_item_i.dep_id),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  dts_ram #(.WIDTH(CW), .DEPTH(MAX_STEPS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (close_we),
    .waddr_i (used_q[SW-1:0]),
    .wdata_i (open_q),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  dts_sweep #(
    .MAX_STEPS (MAX_STEPS),
    .MAX_DEPS  (MAX_DEPS)
  ) u_sweep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (sweep_req),
    .used_i       (used_q),
    .close_we_i   (close_we),
    .close_slot_i (used_q[SW-1:0]),
    .dep_addr_o   (dep_raddr),
    .dep_rdata_i  (dep_rdata),
    .cnt_addr_o   (cnt_raddr),
    .cnt_rdata_i  (cnt_rdata),
    .done_o       (sw_done),
    .tally_o      (sw_tally)
  );

endmodule

// ===== src/dts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dts_sweep.sv =====
// Sweep engine: clears reach marks, walks the graph with a stack, eliminates dead steps.
module dts_sweep #(
  parameter int unsigned MAX_STEPS = dts_pkg::MAX_STEPS_DEF,
  parameter int unsigned MAX_DEPS  = dts_pkg::MAX_DEPS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  dts_pkg::sweep_req_t                            req_i,
  input  logic [$clog2(MAX_STEPS+1)-1:0]                 used_i,
  input  logic                                           close_we_i,
  input  logic [$clog2(MAX_STEPS)-1:0]                   close_slot_i,
  output logic [$clog2(MAX_STEPS)+((MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1)-1:0] dep_addr_o,
  input  logic [dts_pkg::ID_W-1:0]                       dep_rdata_i,
  output logic [$clog2(MAX_STEPS)-1:0]                   cnt_addr_o,
  input  logic [$clog2(MAX_DEPS+1)-1:0]                  cnt_rdata_i,
  output logic                                           done_o,
  output logic [$clog2(MAX_STEPS+1)-1:0]                 tally_o
);

  localparam int unsigned SW   = $clog2(MAX_STEPS);
  localparam int unsigned DW   = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int unsigned UW   = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW   = $clog2(MAX_DEPS + 1);
  localparam int unsigned ID_W = dts_pkg::ID_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SEED, S_POP, S_CUR, S_CNT,
    S_DRD, S_DCHK, S_RCHK, S_ERD, S_ECHK, S_DONE
  } state_e;

  state_e          state_q;
  logic [UW-1:0]   idx_q;
  logic [UW-1:0]   top_q;
  logic [UW-1:0]   tally_q;
  logic [SW-1:0]   cur_q;
  logic [SW-1:0]   slot_q;
  logic [CW-1:0]   k_q;
  logic [CW-1:0]   n_q;
  logic [ID_W-1:0] target_q;

  logic          reach_we, reach_wdata, reach_rdata;
  logic [SW-1:0] reach_waddr, reach_raddr;
  logic          stack_we;
  logic [SW-1:0] stack_waddr, stack_raddr, stack_wdata, stack_rdata;
  logic          elim_we, elim_wdata, elim_rdata;
  logic [SW-1:0] elim_waddr;

  logic          tgt_ok, dep_ok, last_edge, last_idx, dead;
  logic [SW-1:0] tgt_slot, dep_slot;

  // An id names a closed step when it lies in 1..used.
  assign tgt_ok    = (target_q != '0) && (target_q <= ID_W'(used_i));
  assign dep_ok    = (dep_rdata_i != '0) && (dep_rdata_i <= ID_W'(used_i));
  assign tgt_slot  = SW'(target_q - ID_W'(1));
  assign dep_slot  = SW'(dep_rdata_i - ID_W'(1));
  assign last_edge = (k_q + CW'(1)) == n_q;
  assign last_idx  = (idx_q + UW'(1)) == used_i;
  assign dead      = !reach_rdata && !elim_rdata;

  always_comb begin
    reach_we    = 1'b0;
    reach_waddr = idx_q[SW-1:0];
    reach_wdata = 1'b0;
    reach_raddr = idx_q[SW-1:0];
    stack_we    = 1'b0;
    stack_waddr = top_q[SW-1:0];
    stack_wdata = slot_q;
    stack_raddr = SW'(top_q - UW'(1));
    elim_we     = close_we_i;
    elim_waddr  = close_slot_i;
    elim_wdata  = 1'b0;
    dep_addr_o  = {cur_q, k_q[DW-1:0]};
    cnt_addr_o  = stack_rdata;
    case (state_q)
      S_CLR: begin
        reach_we = 1'b1;
      end
      S_SEED: begin
        if (tgt_ok) begin
          reach_we    = 1'b1;
          reach_waddr = tgt_slot;
          reach_wdata = 1'b1;
          stack_we    = 1'b1;
          stack_wdata = tgt_slot;
        end
      end
      S_DCHK: begin
        reach_raddr = dep_slot;
      end
      S_RCHK: begin
        if (!reach_rdata) begin
          reach_we    = 1'b1;
          reach_waddr = slot_q;
          reach_wdata = 1'b1;
          stack_we    = 1'b1;
        end
      end
      S_ECHK: begin
        if (dead) begin
          elim_we    = 1'b1;
          elim_waddr = idx_q[SW-1:0];
          elim_wdata = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      top_q    <= '0;
      tally_q  <= '0;
      cur_q    <= '0;
      slot_q   <= '0;
      k_q      <= '0;
      n_q      <= '0;
      target_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            target_q <= req_i.target;
            idx_q    <= '0;
            top_q    <= '0;
            tally_q  <= '0;
            state_q  <= (used_i == '0) ? S_DONE : S_CLR;
          end
        end
        S_CLR: begin
          if (last_idx) begin
            state_q <= S_SEED;
          end else begin
            idx_q <= idx_q + UW'(1);
          end
        end
        S_SEED: begin
          idx_q <= '0;
          if (tgt_ok) begin
            top_q   <= UW'(1);
            state_q <= S_POP;
          end else begin
            state_q <= S_ERD;
          end
        end
        S_POP: begin
          if (top_q == '0) begin
            state_q <= S_ERD;
          end else begin
            top_q   <= top_q - UW'(1);
            state_q <= S_CUR;
          end
        end
        S_CUR: begin
          cur_q   <= stack_rdata;
          state_q <= S_CNT;
        end
        S_CNT: begin
          n_q     <= cnt_rdata_i;
          k_q     <= '0;
          state_q <= (cnt_rdata_i == '0) ? S_POP : S_DRD;
        end
        S_DRD: begin
          state_q <= S_DCHK;
        end
        S_DCHK: begin
          if (dep_ok) begin
            slot_q  <= dep_slot;
            state_q <= S_RCHK;
          end else if (last_edge) begin
            state_q <= S_POP;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_DRD;
          end
        end
        S_RCHK: begin
          // Push only the first time a step is reached.
          if (!reach_rdata) begin
            top_q <= top_q + UW'(1);
          end
          if (last_edge) begin
            state_q <= S_POP;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_DRD;
          end
        end
        S_ERD: begin
          state_q <= S_ECHK;
        end
        S_ECHK: begin
          if (dead) begin
            tally_q <= tally_q + UW'(1);
          end
          if (last_idx) begin
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + UW'(1);
            state_q <= S_ERD;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o  = (state_q == S_DONE);
  assign tally_o = tally_q;

  dts_ram #(.WIDTH(1), .DEPTH(MAX_STEPS)) u_reach_ram (
    .clk_i   (clk_i),
    .we_i    (reach_we),
    .waddr_i (reach_waddr),
    .wdata_i (reach_wdata),
    .raddr_i (reach_raddr),
    .rdata_o (reach_rdata)
  );

  dts_ram #(.WIDTH(SW), .DEPTH(MAX_STEPS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  dts_ram #(.WIDTH(1), .DEPTH(MAX_STEPS)) u_elim_ram (
    .clk_i   (clk_i),
    .we_i    (elim_we),
    .waddr_i (elim_waddr),
    .wdata_i (elim_wdata),
    .raddr_i (idx_q[SW-1:0]),
    .rdata_o (elim_rdata)
  );

endmodule
